// ===== hdl/kvst_pkg.sv =====
// ---------------------------------------------------------------------------
// kvst_pkg
// Shared types and constants of the keyed vector slot table.
// ---------------------------------------------------------------------------
`default_nettype none

package kvst_pkg;

    // default sizes
    localparam int DEF_SLOTS         = 16;
    localparam int DEF_KEYS          = 64;
    localparam int DEF_MAX_LENGTH    = 16;
    localparam int DEF_ELEMENT_WIDTH = 64;

    // field and register widths
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CAP_W      = 5;
    localparam int LEN_W      = 5;
    localparam int KLIM_W     = 7;

    // register reset values
    localparam logic [CAP_W-1:0]  RST_ACTIVE_SLOTS  = CAP_W'(16);
    localparam logic [LEN_W-1:0]  RST_VECTOR_LENGTH = LEN_W'(16);
    localparam logic [KLIM_W-1:0] RST_KEY_LIMIT     = KLIM_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_PRESENT = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_SLOTS  = 2'd0,
        CFG_VECTOR_LENGTH = 2'd1,
        CFG_KEY_LIMIT     = 2'd2
    } t_cfg_idx;

    // effective configuration and table clear request
    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [LEN_W-1:0]  len;
        logic [KLIM_W-1:0] klim;
        logic              clr;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/kvst_ram.sv =====
// ---------------------------------------------------------------------------
// kvst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module kvst_ram import kvst_pkg::*; #(
    parameter int DEPTH = DEF_KEYS,
    parameter int WIDTH = DEF_ELEMENT_WIDTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/kvst_cfg.sv =====
// ---------------------------------------------------------------------------
// kvst_cfg
// Configuration registers with saturation to the built-in sizes.
// ---------------------------------------------------------------------------
`default_nettype none

module kvst_cfg import kvst_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int KEYS       = DEF_KEYS,
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [CAP_W-1:0]  r_active;
    logic [LEN_W-1:0]  r_vlen;
    logic [KLIM_W-1:0] r_klim;
    logic              hit;

    always_comb begin
        hit = 1'b0;
        unique case (i_cfg_index)
            CFG_ACTIVE_SLOTS, CFG_VECTOR_LENGTH, CFG_KEY_LIMIT: hit = i_cfg_we;
            default: hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RST_ACTIVE_SLOTS;
            r_vlen   <= RST_VECTOR_LENGTH;
            r_klim   <= RST_KEY_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_SLOTS:  r_active <= i_cfg_data[CAP_W-1:0];
                CFG_VECTOR_LENGTH: r_vlen   <= i_cfg_data[LEN_W-1:0];
                CFG_KEY_LIMIT:     r_klim   <= i_cfg_data[KLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.cap  = (int'(r_active) > SLOTS) ? CAP_W'(SLOTS) : r_active;
        if (r_vlen == '0) begin
            o_cfg.len = LEN_W'(1);
        end else begin
            o_cfg.len = (int'(r_vlen) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : r_vlen;
        end
        o_cfg.klim = (int'(r_klim) > KEYS) ? KLIM_W'(KEYS) : r_klim;
        // any write to a listed register empties the table
        o_cfg.clr  = hit;
    end

endmodule

`default_nettype wire

// ===== hdl/kvst_out.sv =====
// ---------------------------------------------------------------------------
// kvst_out
// Result register between the sequencer and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module kvst_out import kvst_pkg::*; #(
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    parameter int OCC_W         = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire logic [STATUS_W-1:0]      i_status,
    input  wire logic [ELEMENT_WIDTH-1:0] i_value,
    input  wire logic                     i_last,
    input  wire logic [OCC_W-1:0]         i_occ,
    input  wire logic                     i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output logic      [STATUS_W-1:0]      o_status,
    output logic      [ELEMENT_WIDTH-1:0] o_read_value,
    output logic                          o_last,
    output logic      [OCC_W-1:0]         o_occupancy
);

    logic                     r_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [ELEMENT_WIDTH-1:0] r_value;
    logic                     r_last;
    logic [OCC_W-1:0]         r_occ;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_status;
            r_value  <= i_value;
            r_last   <= i_last;
            r_occ    <= i_occ;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_value;
    assign o_last       = r_last;
    assign o_occupancy  = r_occ;

endmodule

`default_nettype wire

// ===== hdl/keyed_vector_slot_table.sv =====
// ---------------------------------------------------------------------------
// keyed_vector_slot_table
// Two-way key/slot map with one stored vector per slot.
// ---------------------------------------------------------------------------
// Input channel i_valid/o_stall carries operation, key and one element; the
// output channel o_valid/i_stall carries status, read value, last flag and
// occupancy. An item is taken when valid is high and stall is low.
// One item is worked at a time. On the way from acceptance to the result
// entering the output register, insert continuation, clear and out-of-range
// keys go straight to the result; remove, absent get and a rejected first
// insert item pass key look-up and check; other inserts add a free-slot search
// over the used slots; get adds one vector RAM read per element returned.
// The next item is taken in the cycle after the last result is loaded, even if
// that result is still held by a stalled receiver. A stalled receiver holds
// the sequencer before its next result.
// After reset the key map RAM is swept, during which o_stall stays high;
// configuration writes are taken throughout. A write to a listed configuration
// register empties the table and ends an open insert run.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_vector_slot_table import kvst_pkg::*; #(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int KEYS          = DEF_KEYS,
    parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    localparam int KW  = $clog2(KEYS),
    localparam int SW  = $clog2(SLOTS),
    localparam int HW  = $clog2(SLOTS + 1),
    localparam int LW  = $clog2(MAX_LENGTH + 1),
    localparam int VD  = SLOTS * MAX_LENGTH,
    localparam int VAW = (VD > 1) ? $clog2(VD) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic [KW-1:0]            i_key,
    input  wire logic [ELEMENT_WIDTH-1:0] i_element_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [STATUS_W-1:0]      o_status,
    output logic      [ELEMENT_WIDTH-1:0] o_read_value,
    output logic                          o_last,
    output logic      [HW-1:0]            o_occupancy
);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_SRCH  = 9'b000010000,
        S_INS   = 9'b000100000,
        S_GRD   = 9'b001000000,
        S_GOUT  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    t_cfg cfg;

    t_state             r_state,    n_state;
    t_op                r_op,       n_op;
    logic [KW-1:0]      r_key,      n_key;
    logic [ELEMENT_WIDTH-1:0] r_elem, n_elem;
    logic [SW-1:0]      r_slot,     n_slot;
    t_status            r_st,       n_st;
    logic [LW-1:0]      r_pos,      n_pos;
    logic [SW-1:0]      r_run_slot, n_run_slot;
    t_status            r_run_st,   n_run_st;
    logic [KW-1:0]      r_run_key,  n_run_key;
    logic [HW-1:0]      r_held,     n_held;
    logic [SLOTS-1:0]   r_used,     n_used;
    logic [SW:0]        r_srch,     n_srch;
    logic [LW-1:0]      r_idx,      n_idx;
    logic [KW-1:0]      r_init,     n_init;

    // memory ports
    logic               k2s_we, k2s_re;
    logic [KW-1:0]      k2s_waddr, k2s_raddr;
    logic [SW-1:0]      k2s_wdata, k2s_rdata;
    logic               s2k_we, s2k_re;
    logic [SW-1:0]      s2k_waddr, s2k_raddr;
    logic [KW-1:0]      s2k_wdata, s2k_rdata;
    logic               vs_we, vs_re;
    logic [VAW-1:0]     vs_waddr, vs_raddr;
    logic [ELEMENT_WIDTH-1:0] vs_wdata, vs_rdata;

    // result register load
    logic                     out_free, out_load, out_last;
    t_status                  out_st;
    logic [ELEMENT_WIDTH-1:0] out_val;

    logic in_acc, key_bad, bound;

    kvst_cfg #(
        .SLOTS      (SLOTS),
        .KEYS       (KEYS),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kvst_ram #(.DEPTH(KEYS), .WIDTH(SW)) u_key_to_slot (
        .i_clk   (i_clk),
        .i_we    (k2s_we),
        .i_waddr (k2s_waddr),
        .i_wdata (k2s_wdata),
        .i_re    (k2s_re),
        .i_raddr (k2s_raddr),
        .o_rdata (k2s_rdata)
    );

    kvst_ram #(.DEPTH(SLOTS), .WIDTH(KW)) u_slot_to_key (
        .i_clk   (i_clk),
        .i_we    (s2k_we),
        .i_waddr (s2k_waddr),
        .i_wdata (s2k_wdata),
        .i_re    (s2k_re),
        .i_raddr (s2k_raddr),
        .o_rdata (s2k_rdata)
    );

    kvst_ram #(.DEPTH(VD), .WIDTH(ELEMENT_WIDTH)) u_vector_store (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (vs_waddr),
        .i_wdata (vs_wdata),
        .i_re    (vs_re),
        .i_raddr (vs_raddr),
        .o_rdata (vs_rdata)
    );

    kvst_out #(.ELEMENT_WIDTH(ELEMENT_WIDTH), .OCC_W(HW)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (out_load),
        .i_status     (out_st),
        .i_value      (out_val),
        .i_last       (out_last),
        .i_occ        (n_held),
        .i_stall      (i_stall),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_last       (o_last),
        .o_occupancy  (o_occupancy)
    );

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign key_bad = int'(i_key) >= int'(cfg.klim);
    // a key is bound only if its slot is in use and points back at it,
    // so stale key map entries never need clearing
    assign bound   = r_used[r_slot] && (s2k_rdata == r_key);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_elem     = r_elem;
        n_slot     = r_slot;
        n_st       = r_st;
        n_pos      = r_pos;
        n_run_slot = r_run_slot;
        n_run_st   = r_run_st;
        n_run_key  = r_run_key;
        n_held     = r_held;
        n_used     = r_used;
        n_srch     = r_srch;
        n_idx      = r_idx;
        n_init     = r_init;

        k2s_we    = 1'b0;
        k2s_waddr = r_run_key;
        k2s_wdata = r_run_slot;
        k2s_re    = 1'b0;
        k2s_raddr = i_key;
        s2k_we    = 1'b0;
        s2k_waddr = r_run_slot;
        s2k_wdata = r_run_key;
        s2k_re    = 1'b0;
        s2k_raddr = k2s_rdata;
        vs_we     = 1'b0;
        vs_waddr  = VAW'(int'(r_run_slot) * MAX_LENGTH + int'(r_pos));
        vs_wdata  = r_elem;
        vs_re     = 1'b0;
        vs_raddr  = VAW'(int'(r_slot) * MAX_LENGTH + int'(r_idx));

        out_load  = 1'b0;
        out_st    = r_st;
        out_val   = '0;
        out_last  = 1'b1;

        unique case (r_state)
            S_INIT: begin
                k2s_we    = 1'b1;
                k2s_waddr = r_init;
                k2s_wdata = '0;
                n_init    = r_init + KW'(1);
                if (r_init == KW'(KEYS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = t_op'(i_operation);
                    n_key  = i_key;
                    n_elem = i_element_value;
                    k2s_re = !key_bad;
                    case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (r_pos != '0) begin
                                n_state = S_INS;
                            end else if (key_bad) begin
                                n_run_st = ST_RANGE;
                                n_state  = S_INS;
                            end else begin
                                n_run_key = i_key;
                                n_state   = S_LOOK;
                            end
                        end
                        OP_GET, OP_REMOVE: begin
                            n_pos = '0;
                            if (key_bad) begin
                                n_st    = ST_RANGE;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_LOOK;
                            end
                        end
                        default: begin
                            n_pos    = '0;
                            n_used   = '0;
                            n_held   = '0;
                            n_run_st = ST_OK;
                            n_st     = ST_OK;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                s2k_re  = 1'b1;
                n_slot  = k2s_rdata;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                case (r_op)
                    OP_GET: begin
                        if (bound) begin
                            n_idx   = '0;
                            n_state = S_GRD;
                        end else begin
                            n_st    = ST_ABSENT;
                            n_state = S_RESP;
                        end
                    end
                    OP_REMOVE: begin
                        if (bound) begin
                            n_used[r_slot] = 1'b0;
                            n_held         = r_held - HW'(1);
                            n_st           = ST_OK;
                        end else begin
                            n_st = ST_ABSENT;
                        end
                        n_state = S_RESP;
                    end
                    default: begin
                        if (bound) begin
                            n_run_st = ST_PRESENT;
                            n_state  = S_INS;
                        end else if (int'(r_held) >= int'(cfg.cap)) begin
                            n_run_st = ST_FULL;
                            n_state  = S_INS;
                        end else begin
                            n_srch  = '0;
                            n_state = S_SRCH;
                        end
                    end
                endcase
            end
            S_SRCH: begin
                // walk slots upward to the lowest free one, or report full at the active slot count
                if (int'(r_srch) >= int'(cfg.cap)) begin
                    n_run_st = ST_FULL;
                    n_state  = S_INS;
                end else if (!r_used[r_srch[SW-1:0]]) begin
                    n_run_slot = r_srch[SW-1:0];
                    n_run_st   = ST_OK;
                    n_state    = S_INS;
                end else begin
                    n_srch = r_srch + (SW+1)'(1);
                end
            end
            S_INS: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_st   = r_run_st;
                    vs_we    = (r_run_st == ST_OK);
                    if (int'(r_pos) + 1 >= int'(cfg.len)) begin
                        n_pos = '0;
                        if (r_run_st == ST_OK) begin
                            // bind key and slot both ways at the run's end
                            n_used[r_run_slot] = 1'b1;
                            k2s_we             = 1'b1;
                            s2k_we             = 1'b1;
                            n_held             = r_held + HW'(1);
                        end
                    end else begin
                        n_pos = r_pos + LW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_GRD: begin
                vs_re   = 1'b1;
                n_state = S_GOUT;
            end
            S_GOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_st   = ST_OK;
                    out_val  = vs_rdata;
                    out_last = (int'(r_idx) + 1 == int'(cfg.len));
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = S_GRD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg.clr) begin
            n_used   = '0;
            n_held   = '0;
            n_pos    = '0;
            n_run_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_pos      <= '0;
            r_run_slot <= '0;
            r_run_st   <= ST_OK;
            r_held     <= '0;
            r_used     <= '0;
            r_srch     <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_pos      <= n_pos;
            r_run_slot <= n_run_slot;
            r_run_st   <= n_run_st;
            r_held     <= n_held;
            r_used     <= n_used;
            r_srch     <= n_srch;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_elem    <= n_elem;
        r_slot    <= n_slot;
        r_st      <= n_st;
        r_run_key <= n_run_key;
    end

endmodule

`default_nettype wire

// ===== hdl/kvst_checker.sv =====
// ---------------------------------------------------------------------------
// kvst_checker
// Port-level checks of the keyed vector slot table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module kvst_checker import kvst_pkg::*; #(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    localparam int HW           = $clog2(SLOTS + 1)
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic [STATUS_W-1:0]      o_status,
    input wire logic [ELEMENT_WIDTH-1:0] o_read_value,
    input wire logic                     o_last,
    input wire logic [HW-1:0]            o_occupancy
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status) && $stable(o_read_value)
                               && $stable(o_last) && $stable(o_occupancy))
        else $error("stalled result changed");

    // an error status always answers with a single closing result
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_last && (o_read_value == '0))
        else $error("error result not a single zero item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_RANGE)
                    || (o_status == ST_ABSENT) || (o_status == ST_PRESENT)
                    || (o_status == ST_FULL))
        else $error("status code out of range");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_occupancy) <= SLOTS)
        else $error("occupancy above slot count");

endmodule

bind keyed_vector_slot_table kvst_checker #(
    .SLOTS         (SLOTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_kvst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_last       (o_last),
    .o_occupancy  (o_occupancy)
);

`default_nettype wire

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed vector slot table: a directed table of
// insert, get, remove and clear items, then random phases under several
// register settings. Results are compared with the expected row of the table
// or with a cycle-free model of the key map, slot pool and vector store.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvst_pkg::*;

    localparam int SLOTS       = DEF_SLOTS;
    localparam int KEYS        = DEF_KEYS;
    localparam int MAX_LEN     = DEF_MAX_LENGTH;
    localparam int EW          = DEF_ELEMENT_WIDTH;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 64;
    // index past the register list, written to check that it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_SETUP,
        PRE_SPARE_WRITE
    } t_pre;

    typedef struct {
        t_pre            pre;
        t_op             op;
        logic [5:0]      key;
        logic [EW-1:0]   elem;
        bit              typed;
        t_status         status;
        logic [4:0]      occ;
    } t_stim_row;

    typedef struct {
        t_status         status;
        logic [EW-1:0]   value;
        logic            fin;
        logic [4:0]      occupancy;
    } t_slot_result;

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data      = '0;
    logic                     i_valid         = 1'b0;
    logic                     o_stall;
    logic [OP_W-1:0]          i_operation     = '0;
    logic [5:0]               i_key           = '0;
    logic [EW-1:0]            i_element_value = '0;
    logic                     o_valid;
    logic                     i_stall         = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic [EW-1:0]            o_read_value;
    logic                     o_last;
    logic [4:0]               o_occupancy;

    keyed_vector_slot_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_last          (o_last),
        .o_occupancy     (o_occupancy)
    );

    // model state
    logic [4:0]      reg_slots;
    logic [4:0]      reg_len;
    logic [6:0]      reg_klim;
    int              slot_of_key [KEYS];
    bit              key_bound [KEYS];
    bit              slot_used [SLOTS];
    logic [EW-1:0]   vec_mem [SLOTS*MAX_LEN];
    int              held;
    int              run_pos;
    int              run_slot;
    logic [5:0]      run_key;
    t_status         run_st;

    t_slot_result    pending_results [$];
    int              errors        = 0;
    int              items_sent    = 0;
    int              send_idle_pct = 29;
    int              recv_idle_pct = 57;

    t_stim_row directed_rows [26] = '{
        '{PRE_NONE,        OP_GET,    6'd0,  64'd0,                  1'b1, ST_ABSENT,  5'd0},
        '{PRE_NONE,        OP_GET,    6'd63, 64'd0,                  1'b1, ST_ABSENT,  5'd0},
        '{PRE_NONE,        OP_REMOVE, 6'd63, 64'd0,                  1'b1, ST_ABSENT,  5'd0},
        '{PRE_NONE,        OP_CLEAR,  6'd0,  64'd0,                  1'b1, ST_OK,      5'd0},
        '{PRE_SETUP,       OP_INSERT, 6'd10, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_RANGE,   5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd55, 64'd0,                  1'b1, ST_RANGE,   5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd0,  64'd0,                  1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd0,  64'h1234_5678_9ABC_DEF0, 1'b1, ST_PRESENT, 5'd1},
        '{PRE_NONE,        OP_INSERT, 6'd0,  64'h0FED_CBA9_8765_4321, 1'b1, ST_PRESENT, 5'd1},
        '{PRE_NONE,        OP_INSERT, 6'd9,  64'hA5A5_A5A5_A5A5_A5A5, 1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd9,  64'h5A5A_5A5A_5A5A_5A5A, 1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd5,  64'h0000_0000_0000_0001, 1'b1, ST_FULL,    5'd2},
        '{PRE_NONE,        OP_INSERT, 6'd5,  64'h8000_0000_0000_0000, 1'b1, ST_FULL,    5'd2},
        '{PRE_NONE,        OP_GET,    6'd0,  64'd0,                  1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_GET,    6'd63, 64'd0,                  1'b1, ST_RANGE,   5'd2},
        '{PRE_NONE,        OP_REMOVE, 6'd0,  64'd0,                  1'b1, ST_OK,      5'd1},
        '{PRE_NONE,        OP_GET,    6'd0,  64'd0,                  1'b1, ST_ABSENT,  5'd1},
        '{PRE_NONE,        OP_INSERT, 6'd3,  64'hDEAD_BEEF_0BAD_F00D, 1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_GET,    6'd3,  64'd0,                  1'b1, ST_ABSENT,  5'd1},
        '{PRE_NONE,        OP_INSERT, 6'd3,  64'hC001_D00D_CAFE_BABE, 1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_INSERT, 6'd3,  64'h0123_4567_89AB_CDEF, 1'b0, ST_OK,      5'd0},
        '{PRE_SPARE_WRITE, OP_GET,    6'd3,  64'd0,                  1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_GET,    6'd9,  64'd0,                  1'b0, ST_OK,      5'd0},
        '{PRE_NONE,        OP_CLEAR,  6'd9,  64'd0,                  1'b1, ST_OK,      5'd0},
        '{PRE_NONE,        OP_GET,    6'd9,  64'd0,                  1'b1, ST_ABSENT,  5'd0}
    };

    // active_slots, vector_length, key_limit per random phase
    logic [6:0] phase_cfg [PHASES][3] = '{
        '{7'd16,  7'd1,  7'd64},
        '{7'd1,   7'd16, 7'd64},
        '{7'd0,   7'd3,  7'd127},
        '{7'd31,  7'd0,  7'd0},
        '{7'd4,   7'd31, 7'd20},
        '{7'd3,   7'd2,  7'd8},
        '{7'h7F,  7'd5,  7'd33},
        '{7'd16,  7'd4,  7'd64}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int cap_now();
        return (reg_slots > SLOTS) ? SLOTS : int'(reg_slots);
    endfunction

    function automatic int len_now();
        if (reg_len == 0) return 1;
        return (reg_len > MAX_LEN) ? MAX_LEN : int'(reg_len);
    endfunction

    function automatic int klim_now();
        return (reg_klim > KEYS) ? KEYS : int'(reg_klim);
    endfunction

    function automatic t_status key_status(input logic [5:0] key);
        if (int'(key) >= klim_now()) return ST_RANGE;
        return key_bound[key] ? ST_OK : ST_ABSENT;
    endfunction

    function automatic void empty_table();
        foreach (key_bound[k]) key_bound[k] = 1'b0;
        foreach (slot_used[s]) slot_used[s] = 1'b0;
        held     = 0;
        run_pos  = 0;
        run_slot = 0;
        run_st   = ST_OK;
    endfunction

    function automatic void add_result(input bit record, input t_status st,
                                       input logic [EW-1:0] value, input logic fin);
        if (record) pending_results.push_back('{st, value, fin, 5'(held)});
    endfunction

    function automatic void table_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [6:0] data);
        case (idx)
            CFG_ACTIVE_SLOTS:  reg_slots = data[4:0];
            CFG_VECTOR_LENGTH: reg_len   = data[4:0];
            CFG_KEY_LIMIT:     reg_klim  = data;
            default:           return;
        endcase
        empty_table();
    endfunction

    function automatic void table_step(input t_op op, input logic [5:0] key,
                                       input logic [EW-1:0] elem, input bit record);
        t_status st;
        int      s;
        int      n;
        n = len_now();
        if (op == OP_INSERT) begin
            if (run_pos == 0) begin
                st = key_status(key);
                if (st == ST_RANGE) run_st = ST_RANGE;
                else if (st == ST_OK) run_st = ST_PRESENT;
                else if (held >= cap_now()) run_st = ST_FULL;
                else begin
                    s = 0;
                    while (s < cap_now() && slot_used[s]) s++;
                    if (s >= cap_now()) begin
                        run_st = ST_FULL;
                    end else begin
                        run_st   = ST_OK;
                        run_slot = s;
                        run_key  = key;
                    end
                end
            end
            if (run_st == ST_OK) vec_mem[run_slot*MAX_LEN + run_pos] = elem;
            run_pos++;
            if (run_pos >= n) begin
                // key is bound only once its whole vector is written
                if (run_st == ST_OK) begin
                    slot_used[run_slot]  = 1'b1;
                    slot_of_key[run_key] = run_slot;
                    key_bound[run_key]   = 1'b1;
                    held++;
                end
                run_pos = 0;
            end
            add_result(record, run_st, '0, 1'b1);
            return;
        end
        // anything else drops an open insert run
        run_pos = 0;
        st = key_status(key);
        case (op)
            OP_GET: begin
                if (st != ST_OK) begin
                    add_result(record, st, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        add_result(record, ST_OK, vec_mem[slot_of_key[key]*MAX_LEN + i],
                                   i == n - 1);
                end
            end
            OP_REMOVE: begin
                if (st == ST_OK) begin
                    slot_used[slot_of_key[key]] = 1'b0;
                    key_bound[key] = 1'b0;
                    if (held > 0) held--;
                end
                add_result(record, st, '0, 1'b1);
            end
            default: begin
                empty_table();
                add_result(record, ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [5:0] key, input logic [EW-1:0] elem,
                             input bit typed, input t_status tstat, input logic [4:0] tocc);
        if (items_sent < 180) begin
            send_idle_pct = 29;
            recv_idle_pct = 57;
        end else if (items_sent < 360) begin
            send_idle_pct = 57;
            recv_idle_pct = 29;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_key           <= key;
        i_element_value <= elem;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        table_step(op, key, elem, !typed);
        if (typed) pending_results.push_back('{tstat, '0, 1'b1, tocc});
    endtask

    task automatic send_pred(input t_op op, input logic [5:0] key, input logic [EW-1:0] elem);
        send_item(op, key, elem, 1'b0, ST_OK, '0);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        table_write_reg(idx, data);
    endtask

    function automatic logic [5:0] pick_key();
        int kl;
        kl = klim_now();
        // mostly a small pool of valid keys so that lookups hit
        if (kl == 0 || $urandom_range(99) < 15) return 6'($urandom);
        return 6'($urandom_range((kl > 12) ? 11 : kl - 1, 0));
    endfunction

    task automatic random_action();
        int          r;
        int          n;
        logic [5:0]  key;
        r   = $urandom_range(99);
        n   = len_now();
        key = pick_key();
        if (r < 45) begin
            for (int i = 0; i < n; i++)
                send_pred(OP_INSERT, (i == 0) ? key : 6'($urandom), {$urandom, $urandom});
        end else if (r < 53) begin
            // partial run, cut short by whatever comes next
            n = (n > 1) ? $urandom_range(n - 1, 1) : 1;
            for (int i = 0; i < n; i++)
                send_pred(OP_INSERT, (i == 0) ? key : 6'($urandom), {$urandom, $urandom});
        end else if (r < 73) begin
            send_pred(OP_GET, key, {$urandom, $urandom});
        end else if (r < 87) begin
            send_pred(OP_REMOVE, key, {$urandom, $urandom});
        end else if (r < 91) begin
            send_pred(OP_CLEAR, key, {$urandom, $urandom});
        end else begin
            send_pred(t_op'($urandom_range(3, 0)), 6'($urandom), {$urandom, $urandom});
        end
    endtask

    task automatic check_field(input string name, input logic [EW-1:0] want,
                               input logic [EW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t result expected none actual status %0d value %0h",
                         $time, o_status, o_read_value);
            end else begin
                want = pending_results.pop_front();
                check_field("status", EW'(want.status), EW'(o_status));
                check_field("read_value", want.value, o_read_value);
                check_field("last", EW'(want.fin), EW'(o_last));
                check_field("occupancy", EW'(want.occupancy), EW'(o_occupancy));
            end
        end
    end

    initial begin
        int start;
        reg_slots = RST_ACTIVE_SLOTS;
        reg_len   = RST_VECTOR_LENGTH;
        reg_klim  = RST_KEY_LIMIT;
        foreach (vec_mem[a]) vec_mem[a] = '0;
        foreach (slot_of_key[k]) slot_of_key[k] = 0;
        empty_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].pre == PRE_SETUP) begin
                wait_idle();
                cfg_write(CFG_ACTIVE_SLOTS, 7'd2);
                cfg_write(CFG_VECTOR_LENGTH, 7'd2);
                cfg_write(CFG_KEY_LIMIT, 7'd10);
                i_cfg_we <= 1'b0;
            end else if (directed_rows[r].pre == PRE_SPARE_WRITE) begin
                wait_idle();
                cfg_write(CFG_SPARE, 7'h55);
                i_cfg_we <= 1'b0;
            end
            send_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].elem,
                      directed_rows[r].typed, directed_rows[r].status, directed_rows[r].occ);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            cfg_write(CFG_ACTIVE_SLOTS, phase_cfg[ph][0]);
            cfg_write(CFG_VECTOR_LENGTH, phase_cfg[ph][1]);
            cfg_write(CFG_KEY_LIMIT, phase_cfg[ph][2]);
            i_cfg_we <= 1'b0;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) random_action();
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/kvst_pkg.sv
hdl/kvst_ram.sv
hdl/kvst_cfg.sv
hdl/kvst_out.sv
hdl/keyed_vector_slot_table.sv
hdl/kvst_checker.sv
test/tb.sv
